// File: rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the HTTP response header parser
// Phase codes, string and status-message tables, the classify-to-emit record.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam int BodyMax = 4096;
	localparam int BcW = 13;
	localparam logic [23:0] LenSat = 24'hFFFFFF;
	localparam int QDepth = 4;
	localparam int QAw = 2;

	localparam logic [3:0] PH_VERSION = 4'd0;
	localparam logic [3:0] PH_DIGITS  = 4'd1;
	localparam logic [3:0] PH_TEXT    = 4'd2;
	localparam logic [3:0] PH_HNAME   = 4'd3;
	localparam logic [3:0] PH_HVALUE  = 4'd4;
	localparam logic [3:0] PH_LDIGITS = 4'd5;
	localparam logic [3:0] PH_LSPACES = 4'd6;
	localparam logic [3:0] PH_BODY    = 4'd7;

	// one queue entry: up to two results caused by one byte
	typedef struct packed {
		logic             has_body;
		logic [7:0]       body_byte;
		logic             has_rep;
		logic             ok;
		logic [9:0]       resp_status;
		logic [BcW-1:0]   body_length;
	} hrhp_ent_t;

	function automatic logic [7:0] version_char(input logic [4:0] i);
		case (i)
			5'd0: version_char = "H";
			5'd1: version_char = "T";
			5'd2: version_char = "T";
			5'd3: version_char = "P";
			5'd4: version_char = "/";
			5'd5: version_char = "1";
			default: version_char = ".";
		endcase
	endfunction

	function automatic logic [7:0] name_char(input logic [4:0] i);
		case (i)
			5'd0: name_char = "C";
			5'd1: name_char = "o";
			5'd2: name_char = "n";
			5'd3: name_char = "t";
			5'd4: name_char = "e";
			5'd5: name_char = "n";
			5'd6: name_char = "t";
			5'd7: name_char = "-";
			5'd8: name_char = "L";
			5'd9: name_char = "e";
			5'd10: name_char = "n";
			5'd11: name_char = "g";
			5'd12: name_char = "t";
			default: name_char = "h";
		endcase
	endfunction

	// index of code in the status table, 4'hF when unknown
	function automatic logic [3:0] rom_index(input logic [9:0] code);
		case (code)
			10'd100: rom_index = 4'd0;
			10'd200: rom_index = 4'd1;
			10'd201: rom_index = 4'd2;
			10'd202: rom_index = 4'd3;
			10'd204: rom_index = 4'd4;
			10'd301: rom_index = 4'd5;
			10'd302: rom_index = 4'd6;
			10'd304: rom_index = 4'd7;
			10'd400: rom_index = 4'd8;
			10'd401: rom_index = 4'd9;
			10'd403: rom_index = 4'd10;
			10'd404: rom_index = 4'd11;
			10'd405: rom_index = 4'd12;
			10'd500: rom_index = 4'd13;
			default: rom_index = 4'hF;
		endcase
	endfunction

	function automatic logic [4:0] rom_len(input logic [3:0] e);
		case (e)
			4'd0: rom_len = 5'd8;
			4'd1: rom_len = 5'd2;
			4'd2: rom_len = 5'd7;
			4'd3: rom_len = 5'd8;
			4'd4: rom_len = 5'd10;
			4'd5: rom_len = 5'd17;
			4'd6: rom_len = 5'd5;
			4'd7: rom_len = 5'd12;
			4'd8: rom_len = 5'd11;
			4'd9: rom_len = 5'd12;
			4'd10: rom_len = 5'd9;
			4'd11: rom_len = 5'd9;
			4'd12: rom_len = 5'd18;
			4'd13: rom_len = 5'd21;
			default: rom_len = 5'd0;
		endcase
	endfunction

	function automatic logic [167:0] rom_text(input logic [3:0] e);
		case (e)
			4'd0: rom_text = 168'("Continue");
			4'd1: rom_text = 168'("OK");
			4'd2: rom_text = 168'("Created");
			4'd3: rom_text = 168'("Accepted");
			4'd4: rom_text = 168'("No Content");
			4'd5: rom_text = 168'("Moved Permanently");
			4'd6: rom_text = 168'("Found");
			4'd7: rom_text = 168'("Not Modified");
			4'd8: rom_text = 168'("Bad Request");
			4'd9: rom_text = 168'("Unauthorized");
			4'd10: rom_text = 168'("Forbidden");
			4'd11: rom_text = 168'("Not Found");
			4'd12: rom_text = 168'("Method Not Allowed");
			4'd13: rom_text = 168'("Internal Server Error");
			default: rom_text = '0;
		endcase
	endfunction

	// character pos of message e (strings are right aligned in the vector)
	function automatic logic [7:0] rom_char(input logic [3:0] e, input logic [4:0] pos);
		logic [167:0] t;
		logic [4:0] l;
		logic [4:0] sh;
		t = rom_text(e);
		l = rom_len(e);
		sh = l - pos - 5'd1;
		rom_char = t[{sh, 3'b000} +: 8];
	endfunction

endpackage

// File: rtl/hrhp_front.sv
// ----------------------------------------------------------------------------
// hrhp_front: byte classifier
// Runs the header state machine one byte per cycle while the result queue is not
// full and pushes the results of each byte into the result queue.
// ----------------------------------------------------------------------------
module hrhp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         in_byte,
	input  logic               in_eom,
	input  logic               q_full,
	output logic               take,
	output hrhp_pkg::hrhp_ent_t push_ent
);
	import hrhp_pkg::*;

	logic [3:0]     phase_q, ph;
	logic [4:0]     pos_q, pos;
	logic [9:0]     stat_q, stat;
	logic           nm_q, nm, pc_q, pc, cr_q, cr, le_q, le, ls_q, ls, fail_q, fail;
	logic [23:0]    len_q, len;
	logic [BcW-1:0] bc_q, bc;
	logic [3:0]     ridx;
	logic [BcW:0]   target;
	logic [27:0]    len10;
	logic [7:0]     c;
	logic           isdig, eol, have_status;

	assign take = in_valid && !q_full;
	assign c = in_byte;
	assign isdig = (c >= "0") && (c <= "9");
	assign ridx = rom_index(stat_q);
	assign len10 = {len_q, 3'b000} + {3'b000, len_q, 1'b0} + {20'd0, c - 8'h30};
	always_comb begin
		if (ls_q && len_q < 24'(BodyMax))
			target = (BcW+1)'(len_q);
		else
			target = (BcW+1)'(BodyMax);
	end

	always_comb begin
		ph = phase_q; pos = pos_q; stat = stat_q; nm = nm_q; pc = pc_q; cr = cr_q;
		le = le_q; ls = ls_q; len = len_q; bc = bc_q; fail = fail_q; eol = 1'b0;
		push_ent = '0;
		if (!fail_q) begin
			if (phase_q == PH_BODY) begin
				if ({1'b0, bc_q} < target) begin
					push_ent.has_body = 1'b1;
					push_ent.body_byte = c;
					bc = bc_q + 1'b1;
				end
			end else if (phase_q >= PH_TEXT && phase_q <= PH_LSPACES && cr_q) begin
				cr = 1'b0;
				if (c == 8'h0A) eol = 1'b1;
				else fail = 1'b1;
			end else if (phase_q >= PH_TEXT && phase_q <= PH_LSPACES && c == 8'h0D) begin
				cr = 1'b1;
			end else if (phase_q >= PH_TEXT && phase_q <= PH_LSPACES && c == 8'h0A) begin
				eol = 1'b1;
			end else begin
				case (phase_q)
					PH_VERSION: begin
						if (pos_q < 5'd7) begin
							if (c == version_char(pos_q)) pos = pos_q + 1'b1;
							else fail = 1'b1;
						end else if (pos_q == 5'd7) begin
							if (c == "0" || c == "1") pos = pos_q + 1'b1;
							else fail = 1'b1;
						end else if (c == " ") begin
							ph = PH_DIGITS; pos = '0; stat = '0;
						end else fail = 1'b1;
					end
					PH_DIGITS: begin
						if (pos_q < 5'd3) begin
							if (isdig) begin
								stat = 10'({stat_q, 3'b000} + {stat_q, 1'b0}) + {6'd0, c[3:0]};
								pos = pos_q + 1'b1;
							end else fail = 1'b1;
						end else if (c == " " && ridx != 4'hF) begin
							ph = PH_TEXT; pos = '0;
						end else fail = 1'b1;
					end
					PH_TEXT: begin
						if (ridx != 4'hF && pos_q < rom_len(ridx) && c == rom_char(ridx, pos_q))
							pos = pos_q + 1'b1;
						else fail = 1'b1;
					end
					PH_HNAME: begin
						le = 1'b0;
						if (pc_q && c == " ") begin
							pc = 1'b0;
							if (nm_q && pos_q == 5'd14) begin
								ph = PH_LDIGITS; ls = 1'b1; len = '0;
							end else ph = PH_HVALUE;
						end else begin
							if (pc_q) begin nm = 1'b0; pc = 1'b0; end
							if (c == ":") pc = 1'b1;
							else if (nm && pos_q < 5'd14 && c == name_char(pos_q))
								pos = pos_q + 1'b1;
							else nm = 1'b0;
						end
					end
					PH_LDIGITS: begin
						if (isdig) begin
							if (len10[27:24] != 4'd0) len = LenSat;
							else len = len10[23:0];
						end else if (c == " ") ph = PH_LSPACES;
						else fail = 1'b1;
					end
					PH_LSPACES: begin
						if (c != " ") fail = 1'b1;
					end
					default: ;
				endcase
			end
			if (eol) begin
				case (phase_q)
					PH_TEXT: begin
						if (ridx != 4'hF && pos_q == rom_len(ridx)) begin
							ph = PH_HNAME; pos = '0; nm = 1'b1; pc = 1'b0; le = 1'b1;
						end else fail = 1'b1;
					end
					PH_HNAME: begin
						if (le_q && !pc_q) begin ph = PH_BODY; bc = '0; end
						else fail = 1'b1;
					end
					default: begin
						ph = PH_HNAME; pos = '0; nm = 1'b1; pc = 1'b0; le = 1'b1;
					end
				endcase
			end
		end
		have_status = (ph == PH_DIGITS && pos == 5'd3) || (ph >= PH_TEXT);
		if (in_eom) begin
			push_ent.has_rep = 1'b1;
			push_ent.ok = !fail && ph == PH_BODY;
			push_ent.resp_status = have_status ? stat : 10'd0;
			push_ent.body_length = bc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERSION; pos_q <= '0; stat_q <= '0; nm_q <= 1'b1; pc_q <= 1'b0;
			cr_q <= 1'b0; le_q <= 1'b1; len_q <= '0; ls_q <= 1'b0; bc_q <= '0;
			fail_q <= 1'b0;
		end else if (take) begin
			if (in_eom) begin
				phase_q <= PH_VERSION; pos_q <= '0; stat_q <= '0; nm_q <= 1'b1;
				pc_q <= 1'b0; cr_q <= 1'b0; le_q <= 1'b1; len_q <= '0; ls_q <= 1'b0;
				bc_q <= '0; fail_q <= 1'b0;
			end else begin
				phase_q <= ph; pos_q <= pos; stat_q <= stat; nm_q <= nm; pc_q <= pc;
				cr_q <= cr; le_q <= le; len_q <= len; ls_q <= ls; bc_q <= bc;
				fail_q <= fail;
			end
		end
	end
endmodule

// File: rtl/hrhp_back.sv
// ----------------------------------------------------------------------------
// hrhp_back: result queue and emitter
// Holds per-byte result pairs and sends them one beat at a time.
// ----------------------------------------------------------------------------
module hrhp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  hrhp_pkg::hrhp_ent_t push_ent,
	output logic                q_full,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                kind,
	output logic [7:0]          body_byte,
	output logic                ok,
	output logic [9:0]          resp_status,
	output logic [12:0]         body_length,
	output logic                last
);
	import hrhp_pkg::*;

	hrhp_ent_t      mem_q [QDepth];
	logic [QAw-1:0] wp_q, rp_q;
	logic [QAw:0]   cnt_q;
	logic           half_q; // body part of head entry already sent
	hrhp_ent_t      head;
	logic           do_push, pop, beat, head_ok;

	assign head = mem_q[rp_q];
	assign do_push = push && (push_ent.has_body || push_ent.has_rep);
	assign q_full = cnt_q == (QAw+1)'(QDepth);
	assign head_ok = cnt_q != '0;
	assign out_valid = head_ok;
	assign kind = !(head.has_body && !half_q);
	assign body_byte = kind ? 8'd0 : head.body_byte;
	assign ok = kind ? head.ok : 1'b0;
	assign resp_status = kind ? head.resp_status : 10'd0;
	assign body_length = kind ? head.body_length : '0;
	assign last = kind;
	assign beat = out_valid && !out_stall;
	assign pop = beat && (kind || !head.has_rep);

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= push_ent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0; half_q <= 1'b0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QAw+1)'(do_push) - (QAw+1)'(pop);
			if (pop) half_q <= 1'b0;
			else if (beat) half_q <= 1'b1;
		end
	end
endmodule

// File: rtl/http_response_header_parser.sv
// ----------------------------------------------------------------------------
// http_response_header_parser: HTTP/1.x status line and header parser
// Checks the status line and headers, extracts Content-Length and the body.
// ----------------------------------------------------------------------------
// channel | handshake                  | payload
// input   | in_valid / in_stall        | data_byte, end_of_message
// output  | out_valid / out_stall      | kind, body_byte, ok, resp_status,
//         |                            | body_length, last
// One byte per cycle enters unless the queue is full; the classifier updates its state in that cycle.
// Its results are written into the queue and offered from the queue head.
// A byte may cause two results (body byte and report), sent in two beats.
// A four-entry queue separates classifier and emitter; input stalls only
// when it is full. Reset clears parser state and queue pointers at once.
module http_response_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  body_byte,
	output logic        ok,
	output logic [9:0]  resp_status,
	output logic [12:0] body_length,
	output logic        last
);
	import hrhp_pkg::*;

	logic      q_full, take;
	hrhp_ent_t ent;

	assign in_stall = q_full;

	hrhp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_byte(data_byte),
		.in_eom(end_of_message), .q_full(q_full), .take(take), .push_ent(ent)
	);

	hrhp_back u_back (
		.clk(clk), .arst_n(arst_n), .push(take), .push_ent(ent), .q_full(q_full),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.body_byte(body_byte), .ok(ok), .resp_status(resp_status),
		.body_length(body_length), .last(last)
	);
endmodule

// File: rtl/hrhp_checker.sv
// ----------------------------------------------------------------------------
// hrhp_checker: port-level checks
// Watches the top-level ports for output channel consistency.
// ----------------------------------------------------------------------------
module hrhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        kind,
	input logic [7:0]  body_byte,
	input logic        ok,
	input logic [9:0]  resp_status,
	input logic        last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(body_byte) && $stable(kind))
		else $error("stalled result changed");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last == kind)
		else $error("last differs from kind");
	a_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> !ok && resp_status == 10'd0)
		else $error("body beat carries report fields");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> body_byte == 8'd0 && resp_status <= 10'd999)
		else $error("bad report");
endmodule

bind http_response_header_parser hrhp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.kind(kind), .body_byte(body_byte), .ok(ok), .resp_status(resp_status),
	.last(last)
);

// File: tb/http_response_header_parser_tb.sv
// ----------------------------------------------------------------------------
// http_response_header_parser_tb: self-checking bench for the response parser
// Streams well-formed, corrupted and noise HTTP responses byte by byte with
// random gaps and output stalls; a cycle-free parser model predicts the body
// bytes and final reports, which are checked in order field by field.
// ----------------------------------------------------------------------------
module http_response_header_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hrhp_pkg::*;

	typedef struct {
		bit [7:0] data;
		bit       eom;
	} beat_t;

	typedef struct {
		bit        kind;
		bit [7:0]  body_byte;
		bit        ok;
		bit [9:0]  resp_status;
		bit [12:0] body_length;
		bit        last;
	} result_t;

	localparam int IdleLimit = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  body_byte;
	logic        ok;
	logic [9:0]  resp_status;
	logic [12:0] body_length;
	logic        last;

	http_response_header_parser i_dut (.*);

	beat_t   feed[$];
	result_t expected_results[$];
	int      errors = 0;
	int      n_msgs = 0;
	int      n_body = 0;
	int      n_reports = 0;
	int      n_good = 0;
	int      idle_cycles = 0;
	int      in_gap = 0;
	int      stall_len = 0;
	bit      calm = 1'b0;

	// status table
	int    code_tab[14] = '{100, 200, 201, 202, 204, 301, 302, 304, 400, 401, 403, 404,
		405, 500};
	string text_tab[14] = '{"Continue", "OK", "Created", "Accepted", "No Content",
		"Moved Permanently", "Found", "Not Modified", "Bad Request", "Unauthorized",
		"Forbidden", "Not Found", "Method Not Allowed", "Internal Server Error"};
	string clen_name = "Content-Length";
	string ver_pat = "HTTP/1.";

	// parser state
	logic [3:0]  ph;
	int unsigned pos, code_val, len_val, taken;
	bit          name_ok, after_colon, after_cr, blank_line, len_seen, bad;

	function automatic int code_index(int unsigned code);
		for (int i = 0; i < 14; i++)
			if (code_tab[i] == code) return i;
		return -1;
	endfunction

	function void parser_clear();
		ph = PH_VERSION; pos = 0; code_val = 0; name_ok = 1; after_colon = 0;
		after_cr = 0; blank_line = 1; len_val = 0; len_seen = 0; taken = 0; bad = 0;
	endfunction

	function void start_line();
		ph = PH_HNAME; pos = 0; name_ok = 1; after_colon = 0; blank_line = 1;
	endfunction

	function void close_line();
		int e;
		e = code_index(code_val);
		if (ph == PH_TEXT) begin
			if (e >= 0 && pos == text_tab[e].len()) start_line();
			else bad = 1;
		end else if (ph == PH_HNAME) begin
			if (blank_line && !after_colon) begin
				ph = PH_BODY; taken = 0;
			end else bad = 1;
		end else start_line();
	endfunction

	function void parse_byte(logic [7:0] c);
		int e;
		int unsigned v;
		if (ph >= PH_TEXT && ph <= PH_LSPACES) begin
			if (after_cr) begin
				after_cr = 0;
				if (c == 8'h0A) close_line();
				else bad = 1;
				return;
			end
			if (c == 8'h0D) begin
				after_cr = 1;
				return;
			end
			if (c == 8'h0A) begin
				close_line();
				return;
			end
		end
		case (ph)
			PH_VERSION: begin
				if (pos < 7) begin
					if (c == ver_pat[pos]) pos++;
					else bad = 1;
				end else if (pos == 7) begin
					if (c == "0" || c == "1") pos++;
					else bad = 1;
				end else if (c == " ") begin
					ph = PH_DIGITS; pos = 0; code_val = 0;
				end else bad = 1;
			end
			PH_DIGITS: begin
				if (pos < 3) begin
					if (c >= "0" && c <= "9") begin
						code_val = code_val * 10 + (c - "0"); pos++;
					end else bad = 1;
				end else if (c == " " && code_index(code_val) >= 0) begin
					ph = PH_TEXT; pos = 0;
				end else bad = 1;
			end
			PH_TEXT: begin
				e = code_index(code_val);
				if (e >= 0 && pos < text_tab[e].len() && c == text_tab[e][pos]) pos++;
				else bad = 1;
			end
			PH_HNAME: begin
				blank_line = 0;
				if (after_colon && c == " ") begin
					after_colon = 0;
					if (name_ok && pos == 14) begin
						ph = PH_LDIGITS; len_seen = 1; len_val = 0;
					end else ph = PH_HVALUE;
				end else begin
					if (after_colon) begin
						name_ok = 0; after_colon = 0;
					end
					if (c == ":") after_colon = 1;
					else if (name_ok && pos < 14 && c == clen_name[pos]) pos++;
					else name_ok = 0;
				end
			end
			PH_LDIGITS: begin
				if (c >= "0" && c <= "9") begin
					v = len_val * 10 + (c - "0");
					len_val = (len_val > LenSat / 10 || v > LenSat) ? LenSat : v;
				end else if (c == " ") ph = PH_LSPACES;
				else bad = 1;
			end
			PH_LSPACES: if (c != " ") bad = 1;
			default: ;
		endcase
	endfunction

	// expected results for one accepted beat
	function void predict_beat(logic [7:0] c, bit eom);
		result_t r;
		int unsigned lim;
		if (!bad) begin
			if (ph == PH_BODY) begin
				lim = (len_seen && len_val < BodyMax) ? len_val : BodyMax;
				if (taken < lim) begin
					r = '{0, c, 0, 0, 0, 0};
					expected_results.push_back(r);
					taken++;
					n_body++;
				end
			end else parse_byte(c);
		end
		if (eom) begin
			r.kind = 1;
			r.body_byte = 0;
			r.ok = !bad && ph == PH_BODY;
			r.resp_status = ((ph == PH_DIGITS && pos == 3) || ph >= PH_TEXT) ?
				10'(code_val) : 10'd0;
			r.body_length = 13'(taken);
			r.last = 1;
			expected_results.push_back(r);
			n_reports++;
			if (r.ok) n_good++;
			parser_clear();
		end
	endfunction

	function int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic queue_message(ref byte unsigned msg[$]);
		beat_t b;
		foreach (msg[i]) begin
			b.data = msg[i];
			b.eom = (i == msg.size() - 1);
			feed.push_back(b);
		end
		n_msgs++;
	endtask

	task automatic add_text(ref byte unsigned msg[$], input string s);
		for (int i = 0; i < s.len(); i++) msg.push_back(s[i]);
	endtask

	task automatic add_eol(ref byte unsigned msg[$]);
		if ($urandom_range(1)) add_text(msg, "\r\n");
		else add_text(msg, "\n");
	endtask

	// well-formed response with random content, sometimes damaged
	task automatic build_response(input int body_bytes_forced);
		byte unsigned msg[$];
		int e, nh, clen, nbody, r;
		string s;
		clen = -1;
		add_text(msg, $urandom_range(1) ? "HTTP/1.1 " : "HTTP/1.0 ");
		e = $urandom_range(13);
		if ($urandom_range(19) == 0) begin
			s = $sformatf("%03d", $urandom_range(999));
			add_text(msg, {s, " ", text_tab[e]});
		end else add_text(msg, {$sformatf("%0d", code_tab[e]), " ", text_tab[e]});
		add_eol(msg);
		nh = $urandom_range(3);
		for (int h = 0; h < nh; h++) begin
			r = $urandom_range(9);
			if (r < 5) begin
				add_text(msg, "Content-Length: ");
				if ($urandom_range(29) == 0) begin
					add_text(msg, "99999999");
					clen = BodyMax;
				end else if ($urandom_range(14) == 0) clen = 0;
				else begin
					clen = $urandom_range(12);
					add_text(msg, $sformatf(($urandom_range(3) == 0) ? "%03d" : "%0d", clen));
				end
				for (int k = $urandom_range(2); k > 0; k--) add_text(msg, " ");
			end else if (r < 7) begin
				add_text(msg, ($urandom_range(1)) ? "Content-Lengt: 5" : "content-length: 3");
			end else begin
				add_text(msg, "X-Tag: ");
				for (int k = $urandom_range(6); k > 0; k--)
					msg.push_back(8'($urandom_range(32, 126)));
			end
			add_eol(msg);
		end
		add_eol(msg);
		if (body_bytes_forced >= 0) nbody = body_bytes_forced;
		else if (clen >= 0 && clen < 20) nbody = clen + $urandom_range(4) - 2;
		else nbody = $urandom_range(10);
		if (nbody < 1) nbody = 1;
		for (int k = 0; k < nbody; k++) msg.push_back(8'($urandom_range(255)));
		r = $urandom_range(19);
		if (body_bytes_forced < 0) begin
			if (r == 0) msg[$urandom_range(msg.size() - 1)] = 8'($urandom_range(255));
			else if (r == 1) msg = msg[0:$urandom_range(msg.size() - 1)];
			else if (r == 2) msg.insert($urandom_range(10, msg.size() - 1), 8'h0D);
		end
		queue_message(msg);
	endtask

	task automatic build_noise();
		byte unsigned msg[$];
		for (int k = $urandom_range(1, 10); k > 0; k--) msg.push_back(8'($urandom_range(255)));
		queue_message(msg);
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		beat_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (feed.size() > 0) begin
				b = feed.pop_front();
				data_byte <= b.data;
				end_of_message <= b.eom;
				in_valid <= 1'b1;
				in_gap <= pick_gap();
			end else in_valid <= 1'b0;
		end
	end

	// receiver back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_len <= 0;
		end else if (stall_len > 0) begin
			stall_len <= stall_len - 1;
		end else begin
			out_stall <= !calm && $urandom_range(2) == 0;
			stall_len <= pick_gap();
		end
	end

	// monitor: predict accepted beats, then check the result beat
	always @(posedge clk) begin
		result_t x;
		if (arst_n) begin
			if (in_valid && !in_stall) predict_beat(data_byte, end_of_message);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					x = expected_results.pop_front();
					if (kind !== x.kind) begin
						$error("kind exp %0d got %0d", x.kind, kind); errors++;
					end
					if (body_byte !== x.body_byte) begin
						$error("body_byte exp %0d got %0d", x.body_byte, body_byte); errors++;
					end
					if (ok !== x.ok) begin
						$error("ok exp %0d got %0d", x.ok, ok); errors++;
					end
					if (resp_status !== x.resp_status) begin
						$error("resp_status exp %0d got %0d", x.resp_status, resp_status);
						errors++;
					end
					if (body_length !== x.body_length) begin
						$error("body_length exp %0d got %0d", x.body_length, body_length);
						errors++;
					end
					if (last !== x.last) begin
						$error("last exp %0d got %0d", x.last, last); errors++;
					end
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(feed.size() == 0 && !in_valid && expected_results.size() == 0))
				idle_cycles <= 0;
			else if (idle_cycles >= IdleLimit) begin
				$display("timeout: no beat moved for %0d cycles", IdleLimit);
				$display("http_response_header_parser_tb: FAIL");
				$finish;
			end else idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		byte unsigned msg[$];
		parser_clear();
		// directed: minimal response, LF only, short body, then bare noise, then a CR CR line end
		add_text(msg, "HTTP/1.0 200 OK\n\nAB");
		queue_message(msg);
		msg.delete();
		msg.push_back(8'hFF);
		queue_message(msg);
		msg.delete();
		add_text(msg, "HTTP/1.1 404 Not Found\r\r");
		queue_message(msg);
		while (feed.size() < 2000) begin
			if ($urandom_range(9) == 0) build_noise();
			else build_response(-1);
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (feed.size() > 0 || in_valid || expected_results.size() > 0) begin
			@(posedge clk);
			if ($urandom_range(299) == 0) calm = !calm;
		end
		repeat (50) @(posedge clk);
		$display("covered %0d messages: %0d body bytes, %0d reports (%0d parsed ok)",
			n_msgs, n_body, n_reports, n_good);
		if (errors == 0 && expected_results.size() == 0)
			$display("http_response_header_parser_tb: PASS");
		else
			$display("http_response_header_parser_tb: FAIL");
		$finish;
	end

endmodule
